FILE: hdl/lsba_pkg.sv
// Shared types and constants of the lidar scan bin accumulator.
package lsba_pkg;

    // Angle scale of one full turn, hundredths of a degree
    localparam int unsigned FULL_TURN_CDEG = 36000;
    localparam logic [15:0] FULL_TURN      = 16'(FULL_TURN_CDEG);
    localparam logic [27:0] ROUND_UP       = 28'(FULL_TURN_CDEG - 1);

    // floor(2^32 / 36000); quotient estimate is low by at most one
    localparam logic [16:0] RECIP_MUL   = 17'd119304;
    localparam int unsigned RECIP_SHIFT = 32;

    localparam int unsigned DIST_W = 16;
    localparam int unsigned CONF_W = 8;
    localparam int unsigned NBIN_W = 11;
    localparam int unsigned RIDX_W = 10;
    localparam int unsigned X_W    = 28;
    localparam int unsigned Q_W    = 13;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_DIST    = 3'd0,
        CFG_MAX_DIST    = 3'd1,
        CFG_INVERT      = 3'd2,
        CFG_FILTER_ON   = 3'd3,
        CFG_MASK_LOW    = 3'd4,
        CFG_MASK_HIGH   = 3'd5
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_DIV,
        S_IDX,
        S_READ,
        S_WRITE
    } t_state;

    // One bin as held in the store
    typedef struct packed {
        logic              range_valid;
        logic [DIST_W-1:0] range_mm;
        logic              intensity_valid;
        logic [CONF_W-1:0] intensity;
    } t_bin;

    localparam int unsigned BIN_W = $bits(t_bin);

endpackage

FILE: hdl/lidar_scan_bin_accumulator_top.sv
// Top level of the lidar scan bin accumulator: control, index unit and bin store.
//
// Input channel (i_s_*): one item per handshake. tuser is the mode: 0 adds a point
// to the bin chosen from its angle and the frame's bin count, 1 reads one bin,
// returns it on the output channel and clears it.
// Output channel (o_m_*): one item for every read item, none for a point.
// Configuration channel (i_cfg_*): register index and data, always ready; write
// only while the block is idle.
// Sequence: a point item passes through registered operands, product angle*(N-1),
// reciprocal multiply for the divide by 36000, quotient correction and mirroring,
// store read and write back. A read item passes through store read and write back,
// going straight to write back when its index lies outside the store; its result
// is loaded into the output register at write back, once that register is free.
// One item at a time; the single store port pair and serial multiply chain set this.
// Reset: after i_rst_n is released the store is swept to empty, one bin a cycle,
// addresses 0 to MAX_BINS-1; no item is accepted meanwhile. Configuration registers
// take their reset values at once.
// Stall: a finished result waits in the output register; the block keeps taking
// points meanwhile, and a read item waits before its write back until the
// output register is free.
module lidar_scan_bin_accumulator_top
    import lsba_pkg::*;
#(
    parameter int MAX_BINS = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // slave stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [63:0]           i_s_tdata,  // angle_cdeg[15:0], distance_mm[31:16],
                                              // confidence[39:32], bins_in_frame[50:40],
                                              // bin_index[60:51], zero pad[63:61]
    input  logic                  i_s_tuser,  // mode
    // master stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [23:0]           o_m_tdata,  // range_mm[15:0], intensity[23:16]
    output logic [1:0]            o_m_tuser,  // range_valid[0], intensity_valid[1]
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(MAX_BINS > 1 ? MAX_BINS : 2);
    localparam logic [16:0] MAX_BINS_W = 17'(MAX_BINS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_BINS - 1);

    // input fields
    logic [15:0]       s_angle;
    logic [15:0]       s_dist;
    logic [7:0]        s_conf;
    logic [10:0]       s_nbins;
    logic [RIDX_W-1:0] s_ridx;

    assign s_angle = i_s_tdata[15:0];
    assign s_dist  = i_s_tdata[31:16];
    assign s_conf  = i_s_tdata[39:32];
    assign s_nbins = i_s_tdata[50:40];
    assign s_ridx  = i_s_tdata[60:51];

    // configuration registers
    logic [15:0] r_min_dist;
    logic [15:0] r_max_dist;
    logic        r_invert;
    logic        r_filter_on;
    logic [15:0] r_mask_low;
    logic [15:0] r_mask_high;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_dist  <= 16'd100;
            r_max_dist  <= 16'd50000;
            r_invert    <= 1'b0;
            r_filter_on <= 1'b0;
            r_mask_low  <= 16'd0;
            r_mask_high <= FULL_TURN;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MIN_DIST:  r_min_dist  <= i_cfg_data;
                CFG_MAX_DIST:  r_max_dist  <= i_cfg_data;
                CFG_INVERT:    r_invert    <= i_cfg_data[0];
                CFG_FILTER_ON: r_filter_on <= i_cfg_data[0];
                CFG_MASK_LOW:  r_mask_low  <= i_cfg_data;
                CFG_MASK_HIGH: r_mask_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // control and datapath registers
    t_state            r_state, n_state;
    logic [AW-1:0]     r_clr_addr;
    logic              r_mode;
    logic              r_oob;
    logic [15:0]       r_angle;
    logic [15:0]       r_dist;
    logic [7:0]        r_conf;
    logic [10:0]       r_nm1;
    logic [X_W-1:0]    r_x;
    logic [Q_W-1:0]    r_qe;
    logic              r_rv;
    logic              r_iv;
    logic [AW-1:0]     r_addr;
    logic              r_out_valid;
    t_bin              r_out;

    // bin count clamped to 1..MAX_BINS, minus one
    logic [16:0] nb_ext;
    logic [10:0] nb_sat;
    logic [10:0] nm1_in;
    logic        ridx_oob;
    logic        s_accept;

    assign nb_ext   = {6'd0, s_nbins};
    assign nb_sat   = (nb_ext > MAX_BINS_W) ? MAX_BINS_W[10:0] : s_nbins;
    assign nm1_in   = (nb_sat == 11'd0) ? 11'd0 : nb_sat - 11'd1;
    assign ridx_oob = ({7'd0, s_ridx} >= MAX_BINS_W);
    assign s_accept = i_s_tvalid && o_s_tready;

    // index arithmetic stages
    logic [X_W-1:0]   x_next;
    logic [44:0]      recip_prod;
    logic [X_W-1:0]   q_times;
    logic [X_W-1:0]   rem;
    logic [Q_W-1:0]   q_fix;
    logic [Q_W-1:0]   q_sat;
    logic [Q_W-1:0]   nm1_q;
    logic [Q_W-1:0]   idx_q;
    logic             rv_next;
    logic             masked;

    assign x_next     = X_W'(r_angle) * X_W'(r_nm1) + ROUND_UP;
    assign recip_prod = r_x * RECIP_MUL;
    assign q_times    = X_W'(r_qe) * X_W'(FULL_TURN);
    assign rem        = r_x - q_times;
    assign q_fix      = (rem >= X_W'(FULL_TURN_CDEG)) ? r_qe + Q_W'(1) : r_qe;
    assign nm1_q      = Q_W'(r_nm1);
    assign q_sat      = (q_fix > nm1_q) ? nm1_q : q_fix;
    assign idx_q      = r_invert ? nm1_q - q_sat : q_sat;

    assign rv_next = (r_dist != 16'd0) && (r_dist >= r_min_dist) && (r_dist <= r_max_dist);
    assign masked  = r_filter_on && (r_angle >= r_mask_low) && (r_angle <= r_mask_high);

    // store
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    t_bin             ram_wdata;
    logic             ram_re;
    logic [BIN_W-1:0] ram_rdata;
    t_bin             old_bin;
    t_bin             upd_bin;
    logic             out_free;
    logic             out_load;

    assign old_bin  = t_bin'(ram_rdata);
    assign out_free = !r_out_valid || i_m_tready;

    lsba_ram #(
        .WIDTH (BIN_W),
        .DEPTH (MAX_BINS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    // point update: an empty bin takes any range, a valid one only a smaller valid one
    always_comb begin
        upd_bin = old_bin;
        if (!old_bin.range_valid) begin
            upd_bin.range_valid = r_rv;
            upd_bin.range_mm    = r_rv ? r_dist : 16'd0;
        end else if (r_rv && (r_dist < old_bin.range_mm)) begin
            upd_bin.range_mm = r_dist;
        end
        upd_bin.intensity_valid = r_iv;
        upd_bin.intensity       = r_iv ? r_conf : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_mode  <= i_s_tuser;
            r_angle <= s_angle;
            r_dist  <= s_dist;
            r_conf  <= s_conf;
            r_nm1   <= nm1_in;
            r_oob   <= i_s_tuser && ridx_oob;
            r_addr  <= AW'(s_ridx);
        end
        if (r_state == S_MUL) begin
            r_x  <= x_next;
            r_rv <= rv_next && !masked;
            r_iv <= !masked;
        end
        if (r_state == S_DIV) begin
            r_qe <= recip_prod[RECIP_SHIFT +: Q_W];
        end
        if (r_state == S_IDX) begin
            r_addr <= AW'(idx_q);
        end
        if (out_load) begin
            r_out <= r_oob ? '0 : old_bin;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_s_tready = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = r_addr;
        ram_wdata  = '0;
        ram_re     = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    if (!i_s_tuser) begin
                        n_state = S_MUL;
                    end else if (ridx_oob) begin
                        n_state = S_WRITE;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_MUL:  n_state = S_DIV;
            S_DIV:  n_state = S_IDX;
            S_IDX:  n_state = S_READ;
            S_READ: begin
                ram_re  = 1'b1;
                n_state = S_WRITE;
            end
            S_WRITE: begin
                if (!r_mode) begin
                    ram_we    = 1'b1;
                    ram_wdata = upd_bin;
                    n_state   = S_IDLE;
                end else if (out_free) begin
                    // return the bin and clear it, unless it lies outside the store
                    out_load = 1'b1;
                    ram_we   = !r_oob;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out.intensity, r_out.range_mm};
    assign o_m_tuser  = {r_out.intensity_valid, r_out.range_valid};

endmodule

FILE: hdl/lsba_ram.sv
// Generic simple dual-port RAM with registered read.
module lsba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]               i_wdata,
    input  logic                           i_re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]               o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold read data until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/lsba_checker.sv
// Port-level checks of the lidar scan bin accumulator, bound to the top level.
module lsba_checker
    import lsba_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_tvalid,
    input logic                  o_s_tready,
    input logic [63:0]           i_s_tdata,  // input item fields, see top level
    input logic                  i_s_tuser,  // mode
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [23:0]           o_m_tdata,  // range_mm[15:0], intensity[23:16]
    input logic [1:0]            o_m_tuser,  // range_valid[0], intensity_valid[1]
    input logic                  i_cfg_valid,
    input logic                  o_cfg_ready,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic [CFG_DATA_W-1:0] i_cfg_data
);

    // reset empties the output and starts the store sweep
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && !o_s_tready)
        else $error("outputs active after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    // one item at a time: the cycle after an accept takes nothing
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input accepted back to back");

    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> o_m_tdata[15:0] == 16'd0)
        else $error("invalid range not zero");

    a_intensity_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[1] |-> o_m_tdata[23:16] == 8'd0)
        else $error("invalid intensity not zero");

endmodule

bind lidar_scan_bin_accumulator_top lsba_checker u_lsba_checker (.*);
